// File: rtl/drpb_pkg.sv
// Package for the dirty-row palette buffer: fixed sizes, command codes,
// the request layout and the color arithmetic.
// Depends on nothing; used by the top level dirty_row_palette_buffer.
package drpb_pkg;

    // Default palette size and the fixed geometry of rows and the ramp table.
    localparam int PALETTE_ENTRIES_DEF = 512;
    localparam int ROW_ENTRIES         = 16;
    localparam int HALF_ENTRIES        = 8;
    localparam int RAMP_ENTRIES        = 256;
    localparam int RAMP_AW             = 8;
    localparam int RAMP_W              = 24;
    localparam int COLOR_W             = 16;

    // A transfer sends at most this many rows.
    localparam logic [5:0] MAX_ROWS = 6'd32;

    // Brightness saturates at this value for scaled writes.
    localparam logic signed [15:0] BRIGHT_MAX = 16'sd31;

    // Command codes carried on the input tuser.
    typedef enum logic [2:0] {
        CMD_CLEAR        = 3'd0,
        CMD_WRITE_SCALED = 3'd1,
        CMD_WRITE_RGB8   = 3'd2,
        CMD_WRITE_RAW    = 3'd3,
        CMD_LOAD_RAMP    = 3'd4,
        CMD_TRANSFER     = 3'd5
    } cmd_t;

    // One input request as held by the block.
    typedef struct packed {
        logic [2:0]         cmd;
        logic [8:0]         index;
        logic [7:0]         red;
        logic [7:0]         green;
        logic [7:0]         blue;
        logic signed [15:0] brightness;
        logic               use_ramp;
        logic [15:0]        raw_color;
    } req_t;

    // Negative brightness reads as zero, large values saturate.
    function automatic logic [4:0] clamp_bright(input logic signed [15:0] b);
        logic [4:0] res;
        if (b[15])
            res = 5'd0;
        else if (b > BRIGHT_MAX)
            res = BRIGHT_MAX[4:0];
        else
            res = b[4:0];
        return res;
    endfunction

    // channel * brightness / 256, kept to five bits.
    function automatic logic [4:0] scale_ch(input logic [7:0] ch, input logic [4:0] br);
        logic [12:0] prod;
        prod = {5'd0, ch} * {8'd0, br};
        return prod[12:8];
    endfunction

    // Red in the low bits, green from bit 5, blue from bit 10.
    function automatic logic [COLOR_W-1:0] pack_color(input logic [4:0] r,
                                                      input logic [4:0] g,
                                                      input logic [4:0] b);
        return {1'b0, b, g, r};
    endfunction

endpackage

// File: rtl/drpb_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read.
// Used for the palette store and the ramp table; depends on nothing.
module drpb_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 512,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/dirty_row_palette_buffer.sv
// Top level of the dirty-row palette buffer: command decode, palette and ramp
// memories, dirty flags and the transfer sequencer.
// Depends on drpb_pkg and drpb_ram.

// One request is handled at a time; s_axis_tready is high only when the block
// is idle. After reset, and after every clear command, the palette is zeroed by
// a pass over every entry during which no request is taken. Write rgb8,
// write raw, load ramp, unused codes and scaled writes without the ramp pass
// through the execute state only; a scaled write through the ramp also passes
// through ST_RAMP_G, ST_RAMP_B and ST_RAMP_W, since the three channel
// lookups share the single read port of the ramp memory. A transfer scans
// the rows in turn and reads each half-row of a dirty row into the color
// registers, one color per cycle, from the registered read port of the palette
// memory. Each half-row is then held on the output until it is taken. The final
// half-row of a transfer is sent with tlast once the scan has found no further
// dirty row or MAX_ROWS rows have been sent; tuser on the output is the half bit.
module dirty_row_palette_buffer #(
    parameter int PALETTE_ENTRIES = drpb_pkg::PALETTE_ENTRIES_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // index[8:0], red[16:9], green[24:17], blue[32:25], brightness[48:33],
    // use_ramp[49], raw_color[65:50], zero fill[71:66]
    input  logic [71:0]  s_axis_tdata,
    // cmd[2:0]
    input  logic [2:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // row[4:0], color_a[20:5], color_b[36:21], color_c[52:37], color_d[68:53],
    // color_e[84:69], color_f[100:85], color_g[116:101], color_h[132:117],
    // zero fill[135:133]
    output logic [135:0] m_axis_tdata,
    // half[0]
    output logic         m_axis_tuser,
    output logic         m_axis_tlast
);

    localparam int ROW_COUNT = (PALETTE_ENTRIES + drpb_pkg::ROW_ENTRIES - 1)
                               / drpb_pkg::ROW_ENTRIES;
    localparam int AW  = $clog2(PALETTE_ENTRIES);
    localparam int RW  = (ROW_COUNT > 1) ? $clog2(ROW_COUNT) : 1;
    localparam int RAW = RW + 5;
    localparam int CW  = drpb_pkg::COLOR_W;
    localparam int HE  = drpb_pkg::HALF_ENTRIES;

    localparam logic [RAW-1:0] PAL_LIMIT  = RAW'(PALETTE_ENTRIES);
    localparam logic [RW-1:0]  LAST_ROW   = RW'(ROW_COUNT - 1);
    localparam logic [AW-1:0]  LAST_ENTRY = AW'(PALETTE_ENTRIES - 1);
    localparam logic [3:0]     READ_DONE  = 4'(HE);

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_RAMP_G,
        ST_RAMP_B,
        ST_RAMP_W,
        ST_SCAN,
        ST_READ,
        ST_OUT_H0,
        ST_OUT_MID,
        ST_OUT_END
    } state_t;

    state_t               state_reg;
    drpb_pkg::req_t       req_reg;
    logic [AW-1:0]        sweep_reg;
    logic [ROW_COUNT-1:0] dirty_reg;
    logic [RW-1:0]        scan_reg;
    logic [RW-1:0]        row_reg;
    logic [5:0]           done_reg;
    logic                 half_reg;
    logic [3:0]           k_reg;
    logic                 pend_reg;
    logic                 out_valid_reg;
    logic                 out_last_reg;
    logic                 inrange_reg;
    logic [7:0]           ch_r_reg;
    logic [7:0]           ch_g_reg;
    logic [CW-1:0]        color_reg [HE];

    logic                 pal_we;
    logic [AW-1:0]        pal_waddr;
    logic [CW-1:0]        pal_wdata;
    logic [AW-1:0]        pal_raddr;
    logic [CW-1:0]        pal_rdata;
    logic                 ramp_we;
    logic [drpb_pkg::RAMP_AW-1:0] ramp_raddr;
    logic [drpb_pkg::RAMP_W-1:0]  ramp_rdata;

    logic                 wr_in_range;
    logic [AW+8:0]        idx_ext;
    logic [RW+4:0]        wrow_ext;
    logic [RW-1:0]        wrow;
    logic [RAW-1:0]       rd_full;
    logic [RW+4:0]        row_pad;
    logic [4:0]           bright;
    logic [7:0]           sc_r;
    logic [7:0]           sc_g;
    logic [7:0]           sc_b;
    logic [CW-1:0]        scaled_color;
    logic                 in_req;
    logic                 out_req;

    assign in_req  = s_axis_tvalid && s_axis_tready;
    assign out_req = m_axis_tvalid && m_axis_tready;

    // Address and row of the entry named by the request.
    assign wr_in_range = (32'(req_reg.index) < 32'(PALETTE_ENTRIES));
    assign idx_ext     = {{AW{1'b0}}, req_reg.index};
    assign wrow_ext    = {{RW{1'b0}}, req_reg.index[8:4]};
    assign wrow        = wrow_ext[RW-1:0];

    // Entry being read during a transfer, with a bit to spare for the limit check.
    assign rd_full = {1'b0, row_reg, half_reg, k_reg[2:0]};

    // Scaled color: channels come from the request or from the ramp lookups.
    assign bright = drpb_pkg::clamp_bright(req_reg.brightness);
    always_comb
    begin
        if (state_reg == ST_RAMP_W)
        begin
            sc_r = ch_r_reg;
            sc_g = ch_g_reg;
            sc_b = ramp_rdata[23:16];
        end
        else
        begin
            sc_r = req_reg.red;
            sc_g = req_reg.green;
            sc_b = req_reg.blue;
        end
        scaled_color = drpb_pkg::pack_color(drpb_pkg::scale_ch(sc_r, bright),
                                            drpb_pkg::scale_ch(sc_g, bright),
                                            drpb_pkg::scale_ch(sc_b, bright));
    end

    // Palette write port: clearing pass, direct writes and ramp-scaled writes.
    always_comb
    begin
        pal_we    = 1'b0;
        pal_waddr = idx_ext[AW-1:0];
        pal_wdata = scaled_color;
        if (state_reg == ST_CLEAR)
        begin
            pal_we    = 1'b1;
            pal_waddr = sweep_reg;
            pal_wdata = '0;
        end
        else if (state_reg == ST_RAMP_W)
        begin
            pal_we = wr_in_range;
        end
        else if (state_reg == ST_EXEC)
        begin
            unique case (drpb_pkg::cmd_t'(req_reg.cmd))
                drpb_pkg::CMD_WRITE_SCALED:
                begin
                    pal_we = wr_in_range && !req_reg.use_ramp;
                end
                drpb_pkg::CMD_WRITE_RGB8:
                begin
                    pal_we    = wr_in_range;
                    pal_wdata = drpb_pkg::pack_color(req_reg.red[7:3],
                                                     req_reg.green[7:3],
                                                     req_reg.blue[7:3]);
                end
                drpb_pkg::CMD_WRITE_RAW:
                begin
                    pal_we    = wr_in_range;
                    pal_wdata = req_reg.raw_color;
                end
                default:
                begin
                    pal_we = 1'b0;
                end
            endcase
        end
    end
    assign pal_raddr = rd_full[AW-1:0];

    // Ramp port: loads in the execute cycle, three lookups in a row for scaling.
    assign ramp_we = (state_reg == ST_EXEC)
                     && (drpb_pkg::cmd_t'(req_reg.cmd) == drpb_pkg::CMD_LOAD_RAMP);
    always_comb
    begin
        unique case (state_reg)
            ST_RAMP_G: ramp_raddr = req_reg.green;
            ST_RAMP_B: ramp_raddr = req_reg.blue;
            default:   ramp_raddr = req_reg.red;
        endcase
    end

    drpb_ram #(
        .WIDTH (CW),
        .DEPTH (PALETTE_ENTRIES),
        .AW    (AW)
    ) u_palette (
        .clk   (clk),
        .we    (pal_we),
        .waddr (pal_waddr),
        .wdata (pal_wdata),
        .raddr (pal_raddr),
        .rdata (pal_rdata)
    );

    drpb_ram #(
        .WIDTH (drpb_pkg::RAMP_W),
        .DEPTH (drpb_pkg::RAMP_ENTRIES),
        .AW    (drpb_pkg::RAMP_AW)
    ) u_ramp (
        .clk   (clk),
        .we    (ramp_we),
        .waddr (req_reg.index[7:0]),
        .wdata ({req_reg.blue, req_reg.green, req_reg.red}),
        .raddr (ramp_raddr),
        .rdata (ramp_rdata)
    );

    // Sequencer: state, dirty flags, scan position and output handshake.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            sweep_reg     <= '0;
            dirty_reg     <= '0;
            scan_reg      <= '0;
            row_reg       <= '0;
            done_reg      <= '0;
            half_reg      <= 1'b0;
            k_reg         <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                ST_CLEAR:
                begin
                    sweep_reg <= sweep_reg + 1'b1;
                    if (sweep_reg == LAST_ENTRY)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE:
                begin
                    if (in_req)
                    begin
                        state_reg <= ST_EXEC;
                    end
                end
                ST_EXEC:
                begin
                    state_reg <= ST_IDLE;
                    unique case (drpb_pkg::cmd_t'(req_reg.cmd))
                        drpb_pkg::CMD_CLEAR:
                        begin
                            dirty_reg <= '1;
                            sweep_reg <= '0;
                            state_reg <= ST_CLEAR;
                        end
                        drpb_pkg::CMD_WRITE_SCALED:
                        begin
                            if (req_reg.use_ramp)
                            begin
                                state_reg <= ST_RAMP_G;
                            end
                            else if (wr_in_range)
                            begin
                                dirty_reg[wrow] <= 1'b1;
                            end
                        end
                        drpb_pkg::CMD_WRITE_RGB8,
                        drpb_pkg::CMD_WRITE_RAW:
                        begin
                            if (wr_in_range)
                            begin
                                dirty_reg[wrow] <= 1'b1;
                            end
                        end
                        drpb_pkg::CMD_TRANSFER:
                        begin
                            scan_reg  <= '0;
                            done_reg  <= '0;
                            pend_reg  <= 1'b0;
                            state_reg <= ST_SCAN;
                        end
                        default:
                        begin
                            state_reg <= ST_IDLE;
                        end
                    endcase
                end
                ST_RAMP_G:
                begin
                    state_reg <= ST_RAMP_B;
                end
                ST_RAMP_B:
                begin
                    state_reg <= ST_RAMP_W;
                end
                ST_RAMP_W:
                begin
                    if (wr_in_range)
                    begin
                        dirty_reg[wrow] <= 1'b1;
                    end
                    state_reg <= ST_IDLE;
                end
                ST_SCAN:
                begin
                    // A held second half goes out first; its tlast depends on this find.
                    if (dirty_reg[scan_reg])
                    begin
                        if (pend_reg)
                        begin
                            pend_reg      <= 1'b0;
                            out_valid_reg <= 1'b1;
                            out_last_reg  <= 1'b0;
                            state_reg     <= ST_OUT_MID;
                        end
                        else
                        begin
                            dirty_reg[scan_reg] <= 1'b0;
                            done_reg            <= done_reg + 1'b1;
                            row_reg             <= scan_reg;
                            half_reg            <= 1'b0;
                            k_reg               <= '0;
                            state_reg           <= ST_READ;
                        end
                    end
                    else if (scan_reg == LAST_ROW)
                    begin
                        if (pend_reg)
                        begin
                            pend_reg      <= 1'b0;
                            out_valid_reg <= 1'b1;
                            out_last_reg  <= 1'b1;
                            state_reg     <= ST_OUT_END;
                        end
                        else
                        begin
                            state_reg <= ST_IDLE;
                        end
                    end
                    else
                    begin
                        scan_reg <= scan_reg + 1'b1;
                    end
                end
                ST_READ:
                begin
                    k_reg <= k_reg + 1'b1;
                    if (k_reg == READ_DONE)
                    begin
                        if (!half_reg)
                        begin
                            out_valid_reg <= 1'b1;
                            out_last_reg  <= 1'b0;
                            state_reg     <= ST_OUT_H0;
                        end
                        else if ((done_reg == drpb_pkg::MAX_ROWS) || (scan_reg == LAST_ROW))
                        begin
                            out_valid_reg <= 1'b1;
                            out_last_reg  <= 1'b1;
                            state_reg     <= ST_OUT_END;
                        end
                        else
                        begin
                            pend_reg  <= 1'b1;
                            scan_reg  <= scan_reg + 1'b1;
                            state_reg <= ST_SCAN;
                        end
                    end
                end
                ST_OUT_H0:
                begin
                    if (out_req)
                    begin
                        out_valid_reg <= 1'b0;
                        half_reg      <= 1'b1;
                        k_reg         <= '0;
                        state_reg     <= ST_READ;
                    end
                end
                ST_OUT_MID:
                begin
                    if (out_req)
                    begin
                        out_valid_reg <= 1'b0;
                        state_reg     <= ST_SCAN;
                    end
                end
                ST_OUT_END:
                begin
                    if (out_req)
                    begin
                        out_valid_reg <= 1'b0;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Payload registers: captured request, ramp channels and the half-row colors.
    always_ff @(posedge clk)
    begin
        if (in_req)
        begin
            req_reg.cmd        <= s_axis_tuser;
            req_reg.index      <= s_axis_tdata[8:0];
            req_reg.red        <= s_axis_tdata[16:9];
            req_reg.green      <= s_axis_tdata[24:17];
            req_reg.blue       <= s_axis_tdata[32:25];
            req_reg.brightness <= s_axis_tdata[48:33];
            req_reg.use_ramp   <= s_axis_tdata[49];
            req_reg.raw_color  <= s_axis_tdata[65:50];
        end
        if (state_reg == ST_RAMP_G)
        begin
            ch_r_reg <= ramp_rdata[7:0];
        end
        if (state_reg == ST_RAMP_B)
        begin
            ch_g_reg <= ramp_rdata[15:8];
        end
        // Entries past the end of the palette read as zero.
        inrange_reg <= (rd_full < PAL_LIMIT);
        if ((state_reg == ST_READ) && (k_reg != '0))
        begin
            for (int j = 0; j < HE - 1; j++)
            begin
                color_reg[j] <= color_reg[j+1];
            end
            color_reg[HE-1] <= inrange_reg ? pal_rdata : '0;
        end
    end

    // Output channel.
    assign row_pad       = {5'd0, row_reg};
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tuser  = half_reg;
    assign m_axis_tdata  = {3'd0,
                            color_reg[7], color_reg[6], color_reg[5], color_reg[4],
                            color_reg[3], color_reg[2], color_reg[1], color_reg[0],
                            row_pad[4:0]};

endmodule
